// ----- hdl/csb_pkg.sv -----
// shared constants, request and status codes, controller/datapath interface types
// for the cursor sequence buffer; no dependencies
`default_nettype none

package csb_pkg;

  // storage geometry
  localparam int DEPTH       = 64;
  localparam int VALUE_WIDTH = 32;

  // fixed port widths
  localparam int REQ_W    = 3;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 7;

  // derived widths
  localparam int STORE_W = (VALUE_WIDTH < DATA_W) ? VALUE_WIDTH : DATA_W;
  localparam int PTR_W   = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);

  typedef enum logic [REQ_W-1:0] {
    REQ_START   = 3'd0,
    REQ_ADVANCE = 3'd1,
    REQ_INSERT  = 3'd2,
    REQ_ATTACH  = 3'd3,
    REQ_REMOVE  = 3'd4,
    REQ_READ    = 3'd5
  } req_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE    = 2'd0,
    ST_NO_ITEM = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

  // commands from controller to datapath
  typedef struct packed {
    logic    latch;
    logic    cur_clear;
    logic    cur_inc;
    logic    ins_setup;
    logic    att_setup;
    logic    rem_setup;
    logic    shift_rd;
    logic    shift_wr;
    logic    place;
    logic    dec_count;
    logic    fetch;
    logic    reply;
    logic    set_status;
    status_t status_code;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic has_item;
    logic full;
    logic shift_more;
  } stat_t;

endpackage

`default_nettype wire

// ----- hdl/csb_ctrl.sv -----
// request sequencer for the cursor sequence buffer
// depends on csb_pkg; drives csb_datapath through cmd_t, watches stat_t
`default_nettype none

module csb_ctrl (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    start,
  input  wire logic [csb_pkg::REQ_W-1:0] req_type,
  input  wire csb_pkg::stat_t          stat,
  output csb_pkg::cmd_t                cmd,
  output logic                         busy,
  output logic                         done
);
  import csb_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SH_RD,
    S_SH_WR,
    S_FETCH,
    S_REPLY
  } state_t;

  state_t           state;
  state_t           state_next;
  logic [REQ_W-1:0] req;
  logic             accept;

  assign accept = start && !busy;

  always_comb begin
    cmd        = '0;
    cmd.status_code = ST_DONE;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          cmd.latch  = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        state_next = S_FETCH;
        case (req)
          REQ_START: cmd.cur_clear = 1'b1;
          REQ_ADVANCE: begin
            if (stat.has_item) begin
              cmd.cur_inc = 1'b1;
            end else begin
              cmd.set_status  = 1'b1;
              cmd.status_code = ST_NO_ITEM;
            end
          end
          REQ_INSERT, REQ_ATTACH: begin
            if (stat.full) begin
              cmd.set_status  = 1'b1;
              cmd.status_code = ST_FULL;
            end else begin
              cmd.ins_setup = (req == REQ_INSERT);
              cmd.att_setup = (req == REQ_ATTACH);
              state_next    = S_SH_RD;
            end
          end
          REQ_REMOVE: begin
            if (stat.has_item) begin
              cmd.rem_setup = 1'b1;
              state_next    = S_SH_RD;
            end else begin
              cmd.set_status  = 1'b1;
              cmd.status_code = ST_NO_ITEM;
            end
          end
          default: begin
            if (!stat.has_item) begin
              cmd.set_status  = 1'b1;
              cmd.status_code = ST_NO_ITEM;
            end
          end
        endcase
      end
      S_SH_RD: begin
        if (stat.shift_more) begin
          cmd.shift_rd = 1'b1;
          state_next   = S_SH_WR;
        end else begin
          if (req == REQ_REMOVE) begin
            cmd.dec_count = 1'b1;
          end else begin
            cmd.place = 1'b1;
          end
          state_next = S_FETCH;
        end
      end
      S_SH_WR: begin
        cmd.shift_wr = 1'b1;
        state_next   = S_SH_RD;
      end
      S_FETCH: begin
        cmd.fetch  = 1'b1;
        state_next = S_REPLY;
      end
      S_REPLY: begin
        cmd.reply  = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy  <= 1'b0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      busy  <= (state_next != S_IDLE);
      done  <= (state == S_REPLY);
    end
    if (accept) begin
      req <= req_type;
    end
  end

  a_done_single: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe longer than one cycle");
  a_accept_busy: assert property (@(posedge clk) disable iff (rst) accept |=> busy)
    else $error("busy not raised after accepting a request");
  a_busy_state: assert property (@(posedge clk) disable iff (rst)
    busy == (state != S_IDLE))
    else $error("busy out of step with controller state");

endmodule

`default_nettype wire

// ----- hdl/csb_datapath.sv -----
// item store, cursor, count and result registers of the cursor sequence buffer
// depends on csb_pkg; commanded by csb_ctrl
`default_nettype none

module csb_datapath (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire csb_pkg::cmd_t                cmd,
  input  wire logic [csb_pkg::DATA_W-1:0]   entry_value,
  output csb_pkg::stat_t                    stat,
  output logic [csb_pkg::STATUS_W-1:0]      status,
  output logic [csb_pkg::DATA_W-1:0]        item_value,
  output logic                              has_item,
  output logic [csb_pkg::COUNT_W-1:0]       item_count
);
  import csb_pkg::*;

  logic [STORE_W-1:0] mem [DEPTH];
  logic [STORE_W-1:0] rdata;
  logic [STORE_W-1:0] val;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   cursor;
  logic [CNT_W-1:0]   idx;
  logic               dir_rem;
  status_t            status_r;

  logic               have;
  logic [CNT_W-1:0]   idx_up;
  logic [CNT_W-1:0]   idx_dn;
  logic [CNT_W-1:0]   rd_sel;
  logic [CNT_W-1:0]   wr_sel;
  logic [STORE_W-1:0] wr_data;
  logic               rd_en;
  logic               wr_en;

  assign have   = (cursor < count);
  assign idx_up = idx + 1'b1;
  assign idx_dn = idx - 1'b1;

  assign stat.has_item   = have;
  assign stat.full       = (count >= CNT_W'(DEPTH));
  // remove pulls entries down towards the cursor, insert and attach push them up
  assign stat.shift_more = dir_rem ? (idx_up < count) : (idx > cursor);

  assign rd_en   = cmd.shift_rd || cmd.fetch;
  assign wr_en   = cmd.shift_wr || cmd.place;
  assign rd_sel  = cmd.fetch ? cursor : (dir_rem ? idx_up : idx_dn);
  assign wr_sel  = cmd.place ? cursor : idx;
  assign wr_data = cmd.place ? val : rdata;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_sel[PTR_W-1:0]] <= wr_data;
    end
    if (rd_en) begin
      rdata <= mem[rd_sel[PTR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      cursor <= '0;
    end else begin
      if (cmd.cur_clear) begin
        cursor <= '0;
      end else if (cmd.cur_inc) begin
        cursor <= cursor + 1'b1;
      end else if (cmd.ins_setup) begin
        cursor <= have ? cursor : '0;
      end else if (cmd.att_setup) begin
        cursor <= have ? (cursor + 1'b1) : count;
      end
      if (cmd.place) begin
        count <= count + 1'b1;
      end else if (cmd.dec_count) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      val      <= entry_value[STORE_W-1:0];
      status_r <= ST_DONE;
    end else if (cmd.set_status) begin
      status_r <= cmd.status_code;
    end
    if (cmd.ins_setup || cmd.att_setup) begin
      idx     <= count;
      dir_rem <= 1'b0;
    end else if (cmd.rem_setup) begin
      idx     <= cursor;
      dir_rem <= 1'b1;
    end else if (cmd.shift_wr) begin
      idx <= dir_rem ? idx_up : idx_dn;
    end
    if (cmd.reply) begin
      status     <= status_r;
      item_value <= have ? DATA_W'(rdata) : '0;
      has_item   <= have;
      item_count <= COUNT_W'(count);
    end
  end

  a_cursor_bound: assert property (@(posedge clk) disable iff (rst) cursor <= count)
    else $error("cursor beyond item count");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("item count beyond store depth");
  a_place_grows: assert property (@(posedge clk) disable iff (rst)
    cmd.place |=> count == CNT_W'($past(count) + 1'b1))
    else $error("count did not grow on placing a word");

endmodule

`default_nettype wire

// ----- hdl/cursor_sequence_buffer.sv -----
// top level of the cursor sequence buffer: ordered store with a cursor
// depends on csb_pkg, csb_ctrl and csb_datapath
//
// A request word (req_type, entry_value) is taken at a rising edge where start
// is high and busy is low. Exactly one result word follows on status,
// item_value, has_item and item_count, flagged by done high for a single cycle;
// the receiver cannot hold it off, so it must take it in that cycle. Rewind,
// advance, read and any request that ends in an error pass through the execute,
// fetch and reply states (the result cycle can accept the next request).
// Insert, attach and remove first run a shift sweep, where k is the
// number of stored words moved: count - cursor for an insert before the
// current item, every stored word for an insert with no current item,
// count - cursor - 1 for an attach after it or a remove, and none for an
// attach with no current item. The move costs one read and one write of the
// single-port item store per word; at most DEPTH - 1 words move. No clearing
// pass is needed after reset; an unwritten entry is read only with no current
// item, and item_value then shows zero.
`default_nettype none

module cursor_sequence_buffer (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [csb_pkg::REQ_W-1:0]    req_type,
  input  wire logic [csb_pkg::DATA_W-1:0]   entry_value,
  output logic                              done,
  output logic [csb_pkg::STATUS_W-1:0]      status,
  output logic [csb_pkg::DATA_W-1:0]        item_value,
  output logic                              has_item,
  output logic [csb_pkg::COUNT_W-1:0]       item_count
);
  import csb_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // sequencer: decodes the request and steps through the shift sweep
  csb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .req_type (req_type),
    .stat     (stat),
    .cmd      (cmd),
    .busy     (busy),
    .done     (done)
  );

  // store, cursor and count; result words are registered here
  csb_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .entry_value (entry_value),
    .stat        (stat),
    .status      (status),
    .item_value  (item_value),
    .has_item    (has_item),
    .item_count  (item_count)
  );

endmodule

`default_nettype wire
